@@ rtl/obd_pkg.sv @@
`default_nettype none

package obd_pkg;

    // accepted reply window and mode
    localparam logic [10:0] ID_LOW     = 11'h7E8;
    localparam logic [10:0] ID_HIGH    = 11'h7EF;
    localparam logic [7:0]  MODE_REPLY = 8'h41;

    // parameter identifiers handled by the decoder
    localparam logic [7:0] PID_SUPPORT = 8'h00;
    localparam logic [7:0] PID_LOAD    = 8'h04;
    localparam logic [7:0] PID_COOLANT = 8'h05;
    localparam logic [7:0] PID_MAP     = 8'h0B;
    localparam logic [7:0] PID_RPM     = 8'h0C;
    localparam logic [7:0] PID_SPEED   = 8'h0D;
    localparam logic [7:0] PID_MAF     = 8'h10;
    localparam logic [7:0] PID_FUEL    = 8'h2F;

    // valid mask bit positions
    localparam int MASK_SPEED   = 0;
    localparam int MASK_RPM     = 1;
    localparam int MASK_COOLANT = 2;
    localparam int MASK_FUEL    = 3;
    localparam int MASK_MAP     = 4;
    localparam int MASK_MAF     = 5;
    localparam int MASK_LOAD    = 6;

    // decode constants
    localparam logic [7:0]  COOLANT_OFFSET = 8'd40;
    localparam logic [6:0]  PERCENT_SCALE  = 7'd100;
    // ceil(2^23 / 100), exact quotient for any 16-bit dividend
    localparam logic [16:0] MAF_RECIP      = 17'd83887;
    localparam int          MAF_SHIFT      = 23;

    typedef logic [6:0] t_flags;

endpackage

`default_nettype wire

@@ rtl/obd_pid_response_decoder_top.sv @@
`default_nettype none
// OBD-II mode 01 reply decoder.
// Input channel: one received CAN frame per transfer (identifier, mode byte,
// PID byte and four value bytes), moved when i_valid is high and o_stall low.
// Frames outside identifiers 0x7E8..0x7EF or with a mode byte other than
// 0x41 are taken and dropped without a result.
// Output channel: one record per kept frame (all decoded values, the 7-bit
// valid mask and the 32-bit supported-PID mask), moved when o_valid is high
// and i_stall low. A frame with an unknown PID still yields the record.
// A frame moves from the input register into the record register, which
// drives the ports. Throughput: one frame per cycle while i_stall is low,
// set by the input register and the record register, each a single stage.
// The record register doubles as the decoder state, so it only changes when
// a new record is loaded. While i_stall holds the record, one more frame is
// held in the input register; o_stall rises only when both are full.
// Reset (synchronous, active low) clears all values and masks to zero and
// empties both stages.
module obd_pid_response_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [10:0] i_frame_id,
    input  wire logic [7:0]  i_mode_byte,
    input  wire logic [7:0]  i_pid_byte,
    input  wire logic [7:0]  i_byte_a,
    input  wire logic [7:0]  i_byte_b,
    input  wire logic [7:0]  i_byte_c,
    input  wire logic [7:0]  i_byte_d,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_valid_mask,
    output logic [7:0]       o_speed_kmh,
    output logic [13:0]      o_engine_rpm,
    output logic [7:0]       o_coolant_code,
    output logic [6:0]       o_fuel_percent,
    output logic [7:0]       o_manifold_kpa,
    output logic [9:0]       o_airflow_gps,
    output logic [6:0]       o_load_percent,
    output logic [31:0]      o_supported_mask
);
    import obd_pkg::*;

    // input stage
    logic        r_s1_valid;
    logic [7:0]  r_pid;
    logic [7:0]  r_a;
    logic [7:0]  r_b;
    logic [7:0]  r_c;
    logic [7:0]  r_d;

    // record / state
    logic        r_out_valid;
    t_flags      r_flags;
    logic [7:0]  r_speed;
    logic [13:0] r_rpm;
    logic [7:0]  r_coolant;
    logic [6:0]  r_fuel;
    logic [7:0]  r_map;
    logic [9:0]  r_maf;
    logic [6:0]  r_load;
    logic [31:0] r_support;

    logic        w_adv;
    logic        w_in_xfer;
    logic        w_match;
    logic [15:0] w_ab;
    logic [14:0] w_pct_prod;
    logic [15:0] w_pct_sum;
    logic [6:0]  w_pct;
    logic [32:0] w_maf_prod;

    // handshake: record register frees when empty or taken
    assign w_adv     = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !w_adv;
    assign w_in_xfer = i_valid && !o_stall;
    assign w_match   = (i_frame_id inside {[ID_LOW:ID_HIGH]}) && (i_mode_byte == MODE_REPLY);

    // input register, foreign frames are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= w_match;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_xfer) begin
            r_pid <= i_pid_byte;
            r_a   <= i_byte_a;
            r_b   <= i_byte_b;
            r_c   <= i_byte_c;
            r_d   <= i_byte_d;
        end
    end

    // A*100/255 via x/255 = (x + (x >> 8) + 1) >> 8, exact below 65535
    assign w_ab       = {r_a, r_b};
    assign w_pct_prod = 15'(r_a) * 15'(PERCENT_SCALE);
    assign w_pct_sum  = 16'(w_pct_prod) + 16'(w_pct_prod[14:8]) + 16'd1;
    assign w_pct      = w_pct_sum[14:8];

    // (A*256+B)/100 by reciprocal multiply
    assign w_maf_prod = 33'(w_ab) * 33'(MAF_RECIP);

    // decode and record update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_speed     <= '0;
            r_rpm       <= '0;
            r_coolant   <= '0;
            r_fuel      <= '0;
            r_map       <= '0;
            r_maf       <= '0;
            r_load      <= '0;
            r_support   <= '0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                case (r_pid)
                    PID_SUPPORT: begin
                        r_support <= {r_a, r_b, r_c, r_d};
                    end
                    PID_SPEED: begin
                        r_speed             <= r_a;
                        r_flags[MASK_SPEED] <= 1'b1;
                    end
                    PID_RPM: begin
                        r_rpm             <= w_ab[15:2];
                        r_flags[MASK_RPM] <= 1'b1;
                    end
                    PID_COOLANT: begin
                        r_coolant             <= r_a - COOLANT_OFFSET;
                        r_flags[MASK_COOLANT] <= 1'b1;
                    end
                    PID_FUEL: begin
                        r_fuel             <= w_pct;
                        r_flags[MASK_FUEL] <= 1'b1;
                    end
                    PID_MAP: begin
                        r_map             <= r_a;
                        r_flags[MASK_MAP] <= 1'b1;
                    end
                    PID_MAF: begin
                        r_maf             <= w_maf_prod[MAF_SHIFT+9:MAF_SHIFT];
                        r_flags[MASK_MAF] <= 1'b1;
                    end
                    PID_LOAD: begin
                        r_load             <= w_pct;
                        r_flags[MASK_LOAD] <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // outputs
    assign o_valid          = r_out_valid;
    assign o_valid_mask     = r_flags;
    assign o_speed_kmh      = r_speed;
    assign o_engine_rpm     = r_rpm;
    assign o_coolant_code   = r_coolant;
    assign o_fuel_percent   = r_fuel;
    assign o_manifold_kpa   = r_map;
    assign o_airflow_gps    = r_maf;
    assign o_load_percent   = r_load;
    assign o_supported_mask = r_support;

`ifndef SYNTH
    // valid mask bits never clear outside reset
    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_flags & $past(r_flags)) == $past(r_flags)))
        else $error("valid mask bit cleared");

    // state only moves when a kept frame is loaded
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && w_adv) |=> ($stable(r_flags) && $stable(r_support)))
        else $error("record changed without a frame");

    // percentages stay in range
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fuel <= 7'd100) && (r_load <= 7'd100))
        else $error("percent out of range");

    // input only stalls with a frame held in the input register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with free stages");
`endif

endmodule

`default_nettype wire

@@ tb/sv/obd_pid_response_decoder_top_tb.sv @@
`default_nettype none

module obd_pid_response_decoder_top_tb;

    import obd_pkg::*;

    // one decoded dashboard record as it leaves the block
    typedef struct {
        logic [6:0]  valid_mask;
        logic [7:0]  speed;
        logic [13:0] rpm;
        logic [7:0]  coolant;
        logic [6:0]  fuel;
        logic [7:0]  pressure;
        logic [9:0]  airflow;
        logic [6:0]  load;
        logic [31:0] support;
    } t_dash_record;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [10:0] i_frame_id = '0;
    logic [7:0]  i_mode_byte = '0;
    logic [7:0]  i_pid_byte = '0;
    logic [7:0]  i_byte_a = '0;
    logic [7:0]  i_byte_b = '0;
    logic [7:0]  i_byte_c = '0;
    logic [7:0]  i_byte_d = '0;
    logic        o_stall;
    logic        o_valid;
    logic [6:0]  o_valid_mask;
    logic [7:0]  o_speed_kmh;
    logic [13:0] o_engine_rpm;
    logic [7:0]  o_coolant_code;
    logic [6:0]  o_fuel_percent;
    logic [7:0]  o_manifold_kpa;
    logic [9:0]  o_airflow_gps;
    logic [6:0]  o_load_percent;
    logic [31:0] o_supported_mask;

    t_dash_record dash_state;
    t_dash_record pending_records[$];
    int           error_count = 0;
    int           stall_left = 0;
    bit           no_idle = 1'b0;

    obd_pid_response_decoder_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_frame_id       (i_frame_id),
        .i_mode_byte      (i_mode_byte),
        .i_pid_byte       (i_pid_byte),
        .i_byte_a         (i_byte_a),
        .i_byte_b         (i_byte_b),
        .i_byte_c         (i_byte_c),
        .i_byte_d         (i_byte_d),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_valid_mask     (o_valid_mask),
        .o_speed_kmh      (o_speed_kmh),
        .o_engine_rpm     (o_engine_rpm),
        .o_coolant_code   (o_coolant_code),
        .o_fuel_percent   (o_fuel_percent),
        .o_manifold_kpa   (o_manifold_kpa),
        .o_airflow_gps    (o_airflow_gps),
        .o_load_percent   (o_load_percent),
        .o_supported_mask (o_supported_mask)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #(12 * 200000);
        $display("tb: failure");
        $finish;
    end

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    endtask

    task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // decode one frame into the shadow record and queue the expected record
    task decode_reply(input logic [10:0] id, input logic [7:0] mode, input logic [7:0] pid,
                      input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                      input logic [7:0] d);
        logic [15:0] word_ab;
        int unsigned scaled;
        word_ab = {a, b};
        scaled = (int'(a) * 100) / 255;
        // foreign frames are swallowed without a record
        if (id < ID_LOW || id > ID_HIGH || mode != MODE_REPLY) begin
            return;
        end
        case (pid)
            PID_SUPPORT: dash_state.support = {a, b, c, d};
            PID_SPEED: begin
                dash_state.speed = a;
                dash_state.valid_mask[MASK_SPEED] = 1'b1;
            end
            PID_RPM: begin
                dash_state.rpm = word_ab[15:2];
                dash_state.valid_mask[MASK_RPM] = 1'b1;
            end
            PID_COOLANT: begin
                dash_state.coolant = a - COOLANT_OFFSET;
                dash_state.valid_mask[MASK_COOLANT] = 1'b1;
            end
            PID_FUEL: begin
                dash_state.fuel = scaled[6:0];
                dash_state.valid_mask[MASK_FUEL] = 1'b1;
            end
            PID_MAP: begin
                dash_state.pressure = a;
                dash_state.valid_mask[MASK_MAP] = 1'b1;
            end
            PID_MAF: begin
                dash_state.airflow = 10'(word_ab / 16'd100);
                dash_state.valid_mask[MASK_MAF] = 1'b1;
            end
            PID_LOAD: begin
                dash_state.load = scaled[6:0];
                dash_state.valid_mask[MASK_LOAD] = 1'b1;
            end
            default: ;
        endcase
        pending_records.push_back(dash_state);
    endtask

    // drive one frame and hold it until the transfer, then maybe idle a while
    task send_frame(input logic [10:0] id, input logic [7:0] mode, input logic [7:0] pid,
                    input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                    input logic [7:0] d);
        int gap;
        @(negedge i_clk);
        i_frame_id  <= id;
        i_mode_byte <= mode;
        i_pid_byte  <= pid;
        i_byte_a    <= a;
        i_byte_b    <= b;
        i_byte_c    <= c;
        i_byte_d    <= d;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        decode_reply(id, mode, pid, a, b, c, d);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task release_sender();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task wait_drained();
        while (pending_records.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed replies for known PIDs, with unknown PIDs and foreign frames mixed in
    task random_frame();
        int unsigned roll;
        logic [10:0] id;
        logic [7:0]  mode;
        logic [7:0]  pid;
        roll = $urandom_range(0, 99);
        id   = ID_LOW + 11'($urandom_range(0, 7));
        mode = MODE_REPLY;
        case ($urandom_range(0, 7))
            0: pid = PID_SUPPORT;
            1: pid = PID_SPEED;
            2: pid = PID_RPM;
            3: pid = PID_COOLANT;
            4: pid = PID_FUEL;
            5: pid = PID_MAP;
            6: pid = PID_MAF;
            default: pid = PID_LOAD;
        endcase
        if (roll >= 70 && roll < 80) begin
            pid = 8'($urandom_range(0, 255));
        end else if (roll >= 80 && roll < 90) begin
            id = 11'($urandom_range(0, 2047));
        end else if (roll >= 90) begin
            mode = 8'($urandom_range(0, 255));
        end
        send_frame(id, mode, pid, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // field extremes, every PID and the special cases
    task test_directed_frames();
        // unknown PID right after reset shows the cleared record
        send_frame(ID_LOW,  MODE_REPLY, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // supported mask frames leave the valid mask alone
        send_frame(ID_HIGH, MODE_REPLY, PID_SUPPORT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(ID_LOW,  MODE_REPLY, PID_SUPPORT, 8'h12, 8'h34, 8'h56, 8'h78);
        send_frame(11'h7EA, MODE_REPLY, PID_SPEED, 8'hFF, 8'hAA, 8'h55, 8'hFF);
        send_frame(11'h7EB, MODE_REPLY, PID_SPEED, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_frame(11'h7EC, MODE_REPLY, PID_RPM, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_frame(11'h7ED, MODE_REPLY, PID_RPM, 8'h00, 8'h03, 8'hFF, 8'hFF);
        // coolant wraps below zero
        send_frame(11'h7EE, MODE_REPLY, PID_COOLANT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(ID_HIGH, MODE_REPLY, PID_COOLANT, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_frame(ID_LOW,  MODE_REPLY, PID_COOLANT, 8'd40, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7E9, MODE_REPLY, PID_FUEL, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7E9, MODE_REPLY, PID_FUEL, 8'h01, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7EA, MODE_REPLY, PID_MAP, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7EB, MODE_REPLY, PID_MAF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_frame(11'h7EC, MODE_REPLY, PID_MAF, 8'h00, 8'd99, 8'h00, 8'h00);
        send_frame(11'h7ED, MODE_REPLY, PID_LOAD, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7EE, MODE_REPLY, PID_LOAD, 8'h80, 8'h00, 8'h00, 8'h00);
        // foreign: just outside the window, wrong mode, identifier extremes; then an unknown PID
        send_frame(11'h7E7, MODE_REPLY, PID_SPEED, 8'h11, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7F0, MODE_REPLY, PID_RPM, 8'h22, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7EA, 8'h40, PID_MAP, 8'h33, 8'h00, 8'h00, 8'h00);
        send_frame(11'h000, 8'h00, PID_LOAD, 8'h44, 8'h00, 8'h00, 8'h00);
        send_frame(11'h7FF, MODE_REPLY, PID_FUEL, 8'h55, 8'h00, 8'h00, 8'h00);
        send_frame(ID_LOW, 8'hFF, PID_COOLANT, 8'h66, 8'h00, 8'h00, 8'h00);
        send_frame(ID_HIGH, MODE_REPLY, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(ID_LOW,  MODE_REPLY, PID_SUPPORT, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // sender holds off until every record has come back
    task test_drain_pause();
        repeat (20) random_frame();
        release_sender();
        wait_drained();
        repeat (10) random_frame();
    endtask

    // random traffic with calm stretches
    task test_random_traffic(input int count);
        for (int k = 0; k < count; k++) begin
            no_idle = ((k % 200) >= 170);
            random_frame();
        end
        no_idle = 1'b0;
    endtask

    // back to back transfers at full rate on both sides
    task test_quiet_tail(input int count);
        no_idle = 1'b1;
        repeat (count) random_frame();
    endtask

    // receiver stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare each record transfer with the oldest expected record
    always @(posedge i_clk) begin
        t_dash_record want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_records.size() == 0) begin
                report_mismatch("record with no frame pending", 32'(o_valid_mask), 32'd0);
            end else begin
                want = pending_records.pop_front();
                check_field("valid_mask", 32'(o_valid_mask), 32'(want.valid_mask));
                check_field("speed_kmh", 32'(o_speed_kmh), 32'(want.speed));
                check_field("engine_rpm", 32'(o_engine_rpm), 32'(want.rpm));
                check_field("coolant_code", 32'(o_coolant_code), 32'(want.coolant));
                check_field("fuel_percent", 32'(o_fuel_percent), 32'(want.fuel));
                check_field("manifold_kpa", 32'(o_manifold_kpa), 32'(want.pressure));
                check_field("airflow_gps", 32'(o_airflow_gps), 32'(want.airflow));
                check_field("load_percent", 32'(o_load_percent), 32'(want.load));
                check_field("supported_mask", o_supported_mask, want.support);
            end
        end
    end

    // test sequence
    initial begin
        dash_state = '{default: '0};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_drain_pause();
        test_random_traffic(535);
        test_quiet_tail(60);
        release_sender();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_records.size() != 0) begin
            report_mismatch("records never seen", 32'd0, 32'(pending_records.size()));
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
